// File: design/wavhp_pkg.sv
// Shared types, codes and constants for the WAV header chunk parser.
package wavhp_pkg;

    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_EOF   = 2'd1,
        ACT_BEGIN = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT_HDR   = 3'd1,
        ST_BAD_SIG     = 3'd2,
        ST_MISSING     = 3'd3,
        ST_UNSUPPORTED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_CODEC    = 2'd0,
        CFG_CHANNELS = 2'd1,
        CFG_RATE     = 2'd2,
        CFG_DEPTH    = 2'd3
    } t_cfg_index;

    // Four-character tags, first character in the low byte.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] DEF_CODEC    = 16'd1;
    localparam logic [15:0] DEF_CHANNELS = 16'd2;
    localparam logic [31:0] DEF_RATE     = 32'd48000;
    localparam logic [15:0] DEF_DEPTH    = 16'd16;

    typedef struct packed {
        logic [15:0] codec;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] depth;
    } t_format;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [31:0] size;
        logic [31:0] offset;
    } t_result;

endpackage

// File: design/wav_header_chunk_parser.sv
// Top level of the WAV header chunk parser: handshakes, format registers, result register.
// Items pass from the input register to the result register; an item waits in the input
// register until the result register can take whatever it produces.
// Throughput: one input item per cycle while the input stage is not stalled.
// The input stage stalls only when the result register is full and not being taken.
// Reset (synchronous, active low) clears parse state and both pipeline stages and
// loads the format registers with PCM, two channels, 48000 Hz, 16 bits.
module wav_header_chunk_parser
    import wavhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_file_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_payload_size,
    output logic [31:0] o_payload_offset,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wr_data
);

    // Smallest offset an ok status can report: 12-byte RIFF header, an 8-byte fmt
    // header with its 16 bytes, and the 8-byte data header.
    localparam logic [31:0] MIN_DATA_OFFSET = 32'd44;

    // Format registers; the user must write them only while the block is idle (not enforced here).
    t_format r_required;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_required.codec    <= DEF_CODEC;
            r_required.channels <= DEF_CHANNELS;
            r_required.rate     <= DEF_RATE;
            r_required.depth    <= DEF_DEPTH;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CODEC:    r_required.codec    <= i_cfg_wr_data[15:0];
                CFG_CHANNELS: r_required.channels <= i_cfg_wr_data[15:0];
                CFG_RATE:     r_required.rate     <= i_cfg_wr_data;
                CFG_DEPTH:    r_required.depth    <= i_cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Input register. The held item is processed in the cycle the result
    // register can take whatever it produces, so every step is allowed to emit.
    logic       r_in_valid;
    logic [1:0] r_action;
    logic [7:0] r_byte;
    logic       step;
    logic       r_out_valid;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action <= i_action;
            r_byte   <= i_file_byte;
        end
    end

    // Parser core: all state changes for one byte or command happen in the step cycle.
    t_result res;
    logic    finished;

    wavhp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_action   (t_action'(r_action)),
        .i_byte     (r_byte),
        .i_required (r_required),
        .o_res      (res),
        .o_finished (finished)
    );

    // Result register. It frees itself when the consumer takes the transfer and
    // reloads in the same cycle if the next step emits a status.
    t_status     r_status;
    logic [31:0] r_size;
    logic [31:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.valid) begin
            r_status <= res.status;
            r_size   <= res.size;
            r_offset <= res.offset;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_payload_size   = r_size;
    assign o_payload_offset = r_offset;

    // An ok status always comes with a non-empty data chunk behind a full header.
    a_ok_has_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_OK)
        |-> (r_size != 32'd0 && r_offset >= MIN_DATA_OFFSET))
        else $error("ok status without a plausible data chunk");

    // Any failing status carries zero size and offset.
    a_fail_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK)
        |-> (r_size == 32'd0 && r_offset == 32'd0))
        else $error("failing status with nonzero payload fields");

    // Emitting a status closes the parse until the next begin.
    a_emit_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && res.valid) |=> finished)
        else $error("parser not finished after emitting a status");

    // A finished parse only emits again after a begin command.
    a_single_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && finished && res.valid) |-> 1'b0)
        else $error("second status emitted for one file");

endmodule

// File: design/wavhp_fmt_check.sv
// Compares the captured fmt chunk fields against the required format.
module wavhp_fmt_check
    import wavhp_pkg::*;
(
    input  t_format i_seen,
    input  t_format i_required,
    output logic    o_match
);

    assign o_match = (i_seen.codec == i_required.codec)
                  && (i_seen.channels == i_required.channels)
                  && (i_seen.rate == i_required.rate)
                  && (i_seen.depth == i_required.depth);

endmodule

// File: design/wavhp_parser.sv
// Chunk walking state machine: one file byte or command per step.
module wavhp_parser
    import wavhp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_action i_action,
    input  logic [7:0] i_byte,
    input  t_format i_required,
    output t_result o_res,
    output logic    o_finished
);

    typedef enum logic [1:0] {
        PH_RIFF = 2'd0,
        PH_HEAD = 2'd1,
        PH_FMT  = 2'd2,
        PH_SKIP = 2'd3
    } t_phase;

    localparam logic [4:0]  RIFF_HDR_BYTES  = 5'd12;
    localparam logic [4:0]  CHUNK_HDR_BYTES = 5'd8;
    localparam logic [4:0]  TAG_BYTES       = 5'd4;
    localparam logic [4:0]  FMT_BYTES       = 5'd16;
    localparam logic [4:0]  FMT_CODEC_LO    = 5'd0;
    localparam logic [4:0]  FMT_CODEC_HI    = 5'd1;
    localparam logic [4:0]  FMT_CHAN_LO     = 5'd2;
    localparam logic [4:0]  FMT_CHAN_HI     = 5'd3;
    localparam logic [4:0]  FMT_RATE_B0     = 5'd4;
    localparam logic [4:0]  FMT_RATE_B1     = 5'd5;
    localparam logic [4:0]  FMT_RATE_B2     = 5'd6;
    localparam logic [4:0]  FMT_RATE_B3     = 5'd7;
    localparam logic [4:0]  FMT_DEPTH_LO    = 5'd14;
    localparam logic [4:0]  FMT_DEPTH_HI    = 5'd15;
    localparam logic [31:0] POS_MAX         = '1;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_count, n_count;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_size, n_size;
    logic [31:0] r_skip, n_skip;
    logic [31:0] r_pos, n_pos;
    t_format     r_fmt, n_fmt;
    logic        r_fmt_found, n_fmt_found;
    logic        r_finished, n_finished;

    logic [31:0] byte_sh;
    logic [31:0] pos_inc;
    logic [31:0] skip_dec;
    logic [4:0]  count_inc;
    logic        fmt_match;
    t_result     res;

    wavhp_fmt_check u_fmt_check (
        .i_seen     (r_fmt),
        .i_required (i_required),
        .o_match    (fmt_match)
    );

    assign byte_sh   = {24'h0, i_byte} << {r_count[1:0], 3'b000};
    assign pos_inc   = (r_pos == POS_MAX) ? r_pos : r_pos + 32'd1;
    assign skip_dec  = (r_skip != 32'd0) ? r_skip - 32'd1 : r_skip;
    assign count_inc = r_count + 5'd1;

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_tag       = r_tag;
        n_size      = r_size;
        n_skip      = r_skip;
        n_pos       = r_pos;
        n_fmt       = r_fmt;
        n_fmt_found = r_fmt_found;
        n_finished  = r_finished;
        res         = '0;
        res.status  = ST_OK;

        if (i_step) begin
            unique case (i_action)
                ACT_BEGIN: begin
                    n_phase     = PH_RIFF;
                    n_count     = '0;
                    n_tag       = '0;
                    n_size      = '0;
                    n_skip      = '0;
                    n_pos       = '0;
                    n_fmt       = '0;
                    n_fmt_found = 1'b0;
                    n_finished  = 1'b0;
                end
                ACT_EOF: begin
                    if (!r_finished) begin
                        res.valid  = 1'b1;
                        res.status = (r_phase == PH_RIFF) ? ST_SHORT_HDR : ST_MISSING;
                        n_finished = 1'b1;
                    end
                end
                ACT_BYTE: begin
                    if (!r_finished) begin
                        n_pos = pos_inc;
                        unique case (r_phase)
                            PH_RIFF: begin
                                if (r_count < TAG_BYTES) begin
                                    n_tag = r_tag | byte_sh;
                                end else if (r_count >= CHUNK_HDR_BYTES) begin
                                    n_size = r_size | byte_sh;
                                end
                                n_count = count_inc;
                                if (count_inc >= RIFF_HDR_BYTES) begin
                                    if (n_tag != TAG_RIFF || n_size != TAG_WAVE) begin
                                        res.valid  = 1'b1;
                                        res.status = ST_BAD_SIG;
                                        n_finished = 1'b1;
                                    end else begin
                                        n_phase = PH_HEAD;
                                        n_count = '0;
                                        n_tag   = '0;
                                        n_size  = '0;
                                    end
                                end
                            end
                            PH_HEAD: begin
                                if (r_count < TAG_BYTES) begin
                                    n_tag = r_tag | byte_sh;
                                end else begin
                                    n_size = r_size | byte_sh;
                                end
                                n_count = count_inc;
                                if (count_inc >= CHUNK_HDR_BYTES) begin
                                    if (n_tag == TAG_FMT) begin
                                        n_phase = PH_FMT;
                                        n_count = '0;
                                    end else if (n_tag == TAG_DATA) begin
                                        res.valid  = 1'b1;
                                        n_finished = 1'b1;
                                        if (!r_fmt_found || n_size == 32'd0) begin
                                            res.status = ST_MISSING;
                                        end else if (!fmt_match) begin
                                            res.status = ST_UNSUPPORTED;
                                        end else begin
                                            res.status = ST_OK;
                                            res.size   = n_size;
                                            res.offset = pos_inc;
                                        end
                                    end else if (n_size == 32'd0) begin
                                        n_phase = PH_HEAD;
                                        n_count = '0;
                                        n_tag   = '0;
                                        n_size  = '0;
                                    end else begin
                                        n_skip  = n_size;
                                        n_phase = PH_SKIP;
                                    end
                                end
                            end
                            PH_FMT: begin
                                case (r_count)
                                    FMT_CODEC_LO: n_fmt.codec = {8'h0, i_byte};
                                    FMT_CODEC_HI: n_fmt.codec[15:8] = i_byte;
                                    FMT_CHAN_LO:  n_fmt.channels = {8'h0, i_byte};
                                    FMT_CHAN_HI:  n_fmt.channels[15:8] = i_byte;
                                    FMT_RATE_B0:  n_fmt.rate = {24'h0, i_byte};
                                    FMT_RATE_B1, FMT_RATE_B2, FMT_RATE_B3:
                                        n_fmt.rate = r_fmt.rate | byte_sh;
                                    FMT_DEPTH_LO: n_fmt.depth = {8'h0, i_byte};
                                    FMT_DEPTH_HI: n_fmt.depth[15:8] = i_byte;
                                    default: ;
                                endcase
                                n_count = count_inc;
                                if (count_inc >= FMT_BYTES) begin
                                    n_fmt_found = 1'b1;
                                    if (r_size > {27'h0, FMT_BYTES}) begin
                                        n_skip  = r_size - {27'h0, FMT_BYTES};
                                        n_phase = PH_SKIP;
                                    end else begin
                                        n_phase = PH_HEAD;
                                        n_count = '0;
                                        n_tag   = '0;
                                        n_size  = '0;
                                    end
                                end
                            end
                            PH_SKIP: begin
                                n_skip = skip_dec;
                                if (skip_dec == 32'd0) begin
                                    n_phase = PH_HEAD;
                                    n_count = '0;
                                    n_tag   = '0;
                                    n_size  = '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RIFF;
            r_count     <= '0;
            r_tag       <= '0;
            r_size      <= '0;
            r_skip      <= '0;
            r_pos       <= '0;
            r_fmt       <= '0;
            r_fmt_found <= 1'b0;
            r_finished  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_tag       <= n_tag;
            r_size      <= n_size;
            r_skip      <= n_skip;
            r_pos       <= n_pos;
            r_fmt       <= n_fmt;
            r_fmt_found <= n_fmt_found;
            r_finished  <= n_finished;
        end
    end

    assign o_res      = res;
    assign o_finished = r_finished;

endmodule

// File: tb/wav_header_chunk_parser_checker.sv
// Result checker for the WAV header chunk parser: predicts each status and compares it.
`timescale 1ns / 100ps

module wav_header_chunk_parser_checker
    import wavhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_file_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_payload_size,
    input  logic [31:0] i_payload_offset,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wr_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [1:0] {
        PH_RIFF,
        PH_HEAD,
        PH_FMT,
        PH_SKIP
    } t_phase;

    // Format the block is told to accept.
    t_format     required;

    // Mirror of the parse state.
    t_phase      phase;
    logic [4:0]  field_count;
    logic [31:0] chunk_tag;
    logic [31:0] size_gather;
    logic [31:0] skip_left;
    logic [31:0] file_position;
    t_format     seen;
    logic        fmt_found;
    logic        finished;

    t_result     expected_reports[$];

    function automatic void clear_parse();
        phase         = PH_RIFF;
        field_count   = '0;
        chunk_tag     = '0;
        size_gather   = '0;
        skip_left     = '0;
        file_position = '0;
        seen          = '0;
        fmt_found     = 1'b0;
        finished      = 1'b0;
    endfunction

    function automatic void next_chunk();
        phase       = PH_HEAD;
        field_count = '0;
        chunk_tag   = '0;
        size_gather = '0;
    endfunction

    function automatic logic settle(output t_result res, input t_status st,
                                    input logic [31:0] sz, input logic [31:0] off);
        res.valid  = 1'b1;
        res.status = st;
        res.size   = sz;
        res.offset = off;
        finished   = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic take_byte(input logic [7:0] b, output t_result res);
        logic [31:0] wide;
        wide = {24'd0, b};
        res  = '0;
        if (file_position != '1) file_position++;
        case (phase)
            PH_RIFF: begin
                // Bytes 4 to 7 carry the RIFF size, which is not checked.
                if (field_count < 4)
                    chunk_tag |= wide << (8 * field_count[1:0]);
                else if (field_count >= 8)
                    size_gather |= wide << (8 * field_count[1:0]);
                field_count++;
                if (field_count >= 12) begin
                    if (chunk_tag != TAG_RIFF || size_gather != TAG_WAVE)
                        return settle(res, ST_BAD_SIG, '0, '0);
                    next_chunk();
                end
            end
            PH_HEAD: begin
                if (field_count < 4)
                    chunk_tag |= wide << (8 * field_count[1:0]);
                else
                    size_gather |= wide << (8 * field_count[1:0]);
                field_count++;
                if (field_count == 8) begin
                    if (chunk_tag == TAG_FMT) begin
                        phase       = PH_FMT;
                        field_count = '0;
                    end else if (chunk_tag == TAG_DATA) begin
                        if (!fmt_found || size_gather == '0)
                            return settle(res, ST_MISSING, '0, '0);
                        if (seen != required)
                            return settle(res, ST_UNSUPPORTED, '0, '0);
                        return settle(res, ST_OK, size_gather, file_position);
                    end else if (size_gather == '0) begin
                        next_chunk();
                    end else begin
                        skip_left = size_gather;
                        phase     = PH_SKIP;
                    end
                end
            end
            PH_FMT: begin
                // Byte rate and block align (bytes 8 to 13) are not kept.
                case (field_count)
                    5'd0:  seen.codec           = {8'd0, b};
                    5'd1:  seen.codec[15:8]     = b;
                    5'd2:  seen.channels        = {8'd0, b};
                    5'd3:  seen.channels[15:8]  = b;
                    5'd4:  seen.rate            = wide;
                    5'd5:  seen.rate[15:8]      = b;
                    5'd6:  seen.rate[23:16]     = b;
                    5'd7:  seen.rate[31:24]     = b;
                    5'd14: seen.depth           = {8'd0, b};
                    5'd15: seen.depth[15:8]     = b;
                    default: ;
                endcase
                field_count++;
                if (field_count >= 16) begin
                    fmt_found = 1'b1;
                    if (size_gather > 32'd16) begin
                        skip_left = size_gather - 32'd16;
                        phase     = PH_SKIP;
                    end else begin
                        next_chunk();
                    end
                end
            end
            default: begin
                if (skip_left != '0) skip_left--;
                if (skip_left == '0) next_chunk();
            end
        endcase
        return 1'b0;
    endfunction

    // Advances the mirrored parser by one input item; returns 1 when a status is due.
    function automatic logic parse_item(input logic [1:0] act, input logic [7:0] b,
                                        output t_result res);
        res = '0;
        if (act == ACT_BEGIN) begin
            clear_parse();
            return 1'b0;
        end
        if (act == ACT_NONE || finished) return 1'b0;
        if (act == ACT_EOF)
            return settle(res, (phase == PH_RIFF) ? ST_SHORT_HDR : ST_MISSING, '0, '0);
        return take_byte(b, res);
    endfunction

    always @(posedge i_clk) begin
        t_result res;
        t_result want;
        if (!i_rst_n) begin
            required.codec    = DEF_CODEC;
            required.channels = DEF_CHANNELS;
            required.rate     = DEF_RATE;
            required.depth    = DEF_DEPTH;
            clear_parse();
            expected_reports.delete();
            o_fail_count = 0;
        end else begin
            // A result passes the input and result registers before it leaves, so check before predicting.
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected result: status %0d, size %0d, offset %0d",
                           i_status, i_payload_size, i_payload_offset);
                    o_fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (want.status !== i_status) begin
                        $error("status mismatch: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (want.size !== i_payload_size) begin
                        $error("payload_size mismatch: expected %0d, got %0d",
                               want.size, i_payload_size);
                        o_fail_count++;
                    end
                    if (want.offset !== i_payload_offset) begin
                        $error("payload_offset mismatch: expected %0d, got %0d",
                               want.offset, i_payload_offset);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (parse_item(i_action, i_file_byte, res))
                    expected_reports.push_back(res);
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_CODEC:    required.codec    = i_cfg_wr_data[15:0];
                    CFG_CHANNELS: required.channels = i_cfg_wr_data[15:0];
                    CFG_RATE:     required.rate     = i_cfg_wr_data;
                    CFG_DEPTH:    required.depth    = i_cfg_wr_data[15:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

// File: tb/tb_wav_header_chunk_parser.sv
// Testbench top for the WAV header chunk parser: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module tb_wav_header_chunk_parser;
    import wavhp_pkg::*;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic [1:0]  in_action       = ACT_NONE;
    logic [7:0]  in_byte         = 8'd0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic [2:0]  out_status;
    logic [31:0] out_size;
    logic [31:0] out_offset;
    logic        cfg_wr_en       = 1'b0;
    logic [1:0]  cfg_index       = CFG_CODEC;
    logic [31:0] cfg_wr_data     = 32'd0;

    int          fail_count;
    int          pending;

    // Pacing controls for the sender and the receiver.
    logic        src_idle_en     = 1'b1;
    logic        sink_idle_en    = 1'b1;
    logic        hold_off_req    = 1'b0;

    // The format the block currently requires; files are mostly built to match it.
    t_format     req_fmt;
    int          items_sent      = 0;
    int          files_sent      = 0;

    wav_header_chunk_parser uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_action         (in_action),
        .i_file_byte      (in_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (out_status),
        .o_payload_size   (out_size),
        .o_payload_offset (out_offset),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_wr_data    (cfg_wr_data)
    );

    wav_header_chunk_parser_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_action         (in_action),
        .i_file_byte      (in_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_status         (out_status),
        .i_payload_size   (out_size),
        .i_payload_offset (out_offset),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_wr_data    (cfg_wr_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #5 i_clk = ~i_clk;

    // Offers one item and returns at the edge where its transfer happens. Valid stays
    // high afterwards, so back-to-back calls stream without a bubble. A random gap is
    // sometimes opened first while idling is enabled.
    task automatic send_item(input t_action act, input logic [7:0] b);
        if (src_idle_en && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_byte   <= b;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (act != ACT_NONE) items_sent++;
    endtask

    // A file byte, occasionally preceded by the unused action code, which must be ignored.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 49) == 0) send_item(ACT_NONE, 8'($urandom));
        send_item(ACT_BYTE, b);
    endtask

    // Sends the low n bytes of a word, least significant first, as a file stores them.
    task automatic send_word(input logic [31:0] w, input int n);
        for (int k = 0; k < n; k++) send_byte(w[8*k +: 8]);
    endtask

    // Sender pause: lower valid, then wait until every expected status has been taken.
    // A final wait covers items still in flight that cause no status.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write; the enable stays high so consecutive writes go back to back.
    task automatic put_reg(input t_cfg_index idx, input logic [31:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge i_clk);
    endtask

    // Loads all four format registers. The upper half of the 16-bit ones gets junk,
    // which the block has to drop.
    task automatic write_format(input t_format f);
        put_reg(CFG_CODEC,    {16'($urandom), f.codec});
        put_reg(CFG_CHANNELS, {16'($urandom), f.channels});
        put_reg(CFG_RATE,     f.rate);
        put_reg(CFG_DEPTH,    {16'($urandom), f.depth});
        cfg_wr_en <= 1'b0;
        req_fmt = f;
    endtask

    // A chunk the parser does not know, skipped whole. Size zero tests the direct
    // return to the next chunk header.
    task automatic send_other_chunk();
        logic [31:0] tag;
        logic [31:0] len;
        tag = $urandom;
        if (tag == TAG_FMT || tag == TAG_DATA) tag = 32'h5453_494c;
        len = ($urandom_range(0, 9) < 3) ? 32'd0 : 32'($urandom_range(1, 8));
        send_word(tag, 4);
        send_word(len, 4);
        repeat (len) send_byte(8'($urandom));
    endtask

    // A fmt chunk, mostly matching the required format. Its size is usually 16, at
    // times larger (the excess is skipped) and at times smaller (16 bytes are taken
    // regardless).
    task automatic send_fmt_chunk();
        t_format     f;
        logic [31:0] len;
        int          r;
        f = req_fmt;
        r = $urandom_range(0, 99);
        if (r < 6)       f.codec    = 16'($urandom);
        else if (r < 12) f.channels = 16'($urandom);
        else if (r < 18) f.rate     = $urandom;
        else if (r < 24) f.depth    = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 70)      len = 32'd16;
        else if (r < 88) len = 32'(16 + $urandom_range(1, 6));
        else             len = 32'($urandom_range(0, 15));
        send_word(TAG_FMT, 4);
        send_word(len, 4);
        send_word({16'd0, f.codec}, 2);
        send_word({16'd0, f.channels}, 2);
        send_word(f.rate, 4);
        send_word($urandom, 4);
        send_word($urandom, 2);
        send_word({16'd0, f.depth}, 2);
        if (len > 32'd16) repeat (len - 32'd16) send_byte(8'($urandom));
    endtask

    function automatic logic [31:0] pick_data_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)  return 32'd0;
        if (r < 16) return 32'hFFFF_FFFF;
        if (r < 46) return $urandom;
        return 32'($urandom_range(1, 4096));
    endfunction

    // One file from begin to its status. Most files are well formed with random
    // content; the rest are cut short, carry a broken signature, lack a fmt chunk,
    // end without a data chunk or are abandoned by the next begin.
    task automatic make_file();
        logic [7:0]  hdr [12];
        logic [31:0] body_len;
        int          kind;
        int          cut;
        int          pos;
        int          ending;
        body_len = $urandom;
        for (int k = 0; k < 4; k++) begin
            hdr[k]     = TAG_RIFF[8*k +: 8];
            hdr[k + 4] = body_len[8*k +: 8];
            hdr[k + 8] = TAG_WAVE[8*k +: 8];
        end
        send_item(ACT_BEGIN, 8'($urandom));
        files_sent++;
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            // End of file inside the RIFF header.
            cut = $urandom_range(0, 11);
            for (int k = 0; k < cut; k++) send_byte(hdr[k]);
            send_item(ACT_EOF, 8'($urandom));
            return;
        end
        if (kind < 12) begin
            // Break one signature byte; the size bytes are not checked.
            pos = $urandom_range(0, 7);
            if (pos >= 4) pos += 4;
            hdr[pos] ^= 8'($urandom_range(1, 255));
        end
        for (int k = 0; k < 12; k++) send_byte(hdr[k]);
        if (kind < 12) begin
            // The status is already out; what follows must be ignored.
            send_byte(8'($urandom));
            send_item(ACT_EOF, 8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 2)) send_other_chunk();
        if ($urandom_range(0, 9) != 0) send_fmt_chunk();
        if ($urandom_range(0, 3) == 0) send_other_chunk();
        ending = $urandom_range(0, 99);
        if (ending < 8) begin
            // End of file with a chunk header possibly half sent.
            repeat ($urandom_range(0, 7)) send_byte(8'($urandom));
            send_item(ACT_EOF, 8'($urandom));
        end else if (ending >= 12) begin
            send_word(TAG_DATA, 4);
            send_word(pick_data_size(), 4);
            // Payload bytes and a late end of file come after the status and are ignored.
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            if ($urandom_range(0, 1) == 0) send_item(ACT_EOF, 8'($urandom));
        end
        // Otherwise the file is abandoned and the next begin starts over.
    endtask

    task automatic run_files(input int budget, input int min_files);
        int item_base;
        int file_base;
        item_base = items_sent;
        file_base = files_sent;
        while (items_sent - item_base < budget || files_sent - file_base < min_files)
            make_file();
    endtask

    // Receiver. Ready comes in random stretches with random stall bursts
    // while idling is enabled. On request it holds off for a long, cycle-counted
    // stretch so the result stage fills and the input stalls.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // Main sequence: reset, directed items, then random files under several formats.
    initial begin
        req_fmt.codec    = DEF_CODEC;
        req_fmt.channels = DEF_CHANNELS;
        req_fmt.rate     = DEF_RATE;
        req_fmt.depth    = DEF_DEPTH;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: the unused action, end of file at once and inside the header,
        // items after a status, and a broken WAVE signature with extreme byte values.
        send_item(ACT_NONE, 8'hFF);
        send_item(ACT_EOF, 8'h00);
        send_item(ACT_EOF, 8'hFF);
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BEGIN, 8'hFF);
        send_word(TAG_RIFF, 3);
        send_item(ACT_EOF, 8'h00);
        send_item(ACT_BEGIN, 8'h00);
        send_word(TAG_RIFF, 4);
        send_word(32'hFFFF_FFFF, 4);
        send_word(TAG_WAVE & 32'h00FF_FFFF, 4);

        // Reset format, no register written yet.
        run_files(320, 8);

        // All registers at zero. The receiver holds off while short files pile up
        // results, so the block has to stall its input.
        drain();
        write_format('0);
        hold_off_req = 1'b1;
        repeat (30) begin
            send_item(ACT_BEGIN, 8'($urandom));
            send_item(ACT_EOF, 8'($urandom));
        end
        run_files(320, 8);

        // All registers at their maximum.
        drain();
        write_format('1);
        run_files(320, 8);

        // Random format.
        drain();
        write_format({16'($urandom), 16'($urandom), 32'($urandom), 16'($urandom)});
        run_files(320, 8);

        // A common format, with both sides streaming and no idling at all.
        drain();
        write_format({16'd1, 16'd2, 32'd44100, 16'd24});
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_files(320, 8);

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("wav_header_chunk_parser test passed");
        end else begin
            $display("wav_header_chunk_parser test failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("wav_header_chunk_parser test failed");
        $finish;
    end

endmodule

// File: filelist.f
design/wavhp_pkg.sv
design/wavhp_fmt_check.sv
design/wavhp_parser.sv
design/wav_header_chunk_parser.sv
tb/wav_header_chunk_parser_checker.sv
tb/tb_wav_header_chunk_parser.sv
